### hw/rtl/recording_level_meter_macros.svh
// Assertion macros for the recording level meter.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef RECORDING_LEVEL_METER_MACROS_SVH
`define RECORDING_LEVEL_METER_MACROS_SVH

// Same-cycle implication, off during reset.
`define RLM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define RLM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rlm_pkg.sv
// Shared widths, constants, register indexes, state type and result struct of the level meter.
// No dependencies.
package rlm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = 21;
	localparam int IDX_W    = 20;
	localparam int RATE_W   = 18;
	localparam int DUR_W    = 30;
	localparam int SUM_W    = 51;
	localparam int MEAN_W   = 31;
	localparam int LVL_W    = 16;
	localparam int SQ_W     = 2 * SAMPLE_W;
	localparam int SQIN_W   = 2 * LVL_W;
	localparam int SREM_W   = LVL_W + 2;
	localparam int CHUNK_BITS = 9;   // 512-sample chunks

	localparam int DIV_STEPS  = SUM_W;
	localparam int DUR_STEPS  = DUR_W;
	localparam int SQRT_STEPS = LVL_W;
	localparam int STEP_W     = 6;

	localparam logic [CNT_W-1:0]  MAX_DEPTH = CNT_W'(1048576);
	localparam logic [DUR_W-1:0]  MS_PER_S  = DUR_W'(1000);

	localparam logic [CNT_W-1:0]  RST_MAX_SAMPLES  = CNT_W'(160000);
	localparam logic [CNT_W-1:0]  RST_MIN_SAMPLES  = CNT_W'(12800);
	localparam logic [CNT_W-1:0]  RST_TAIL_SAMPLES = CNT_W'(4000);
	localparam logic [RATE_W-1:0] RST_SAMPLE_RATE  = RATE_W'(16000);

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef enum logic [1:0] {
		REG_MAX_SAMPLES  = 2'd0,
		REG_MIN_SAMPLES  = 2'd1,
		REG_TAIL_SAMPLES = 2'd2,
		REG_SAMPLE_RATE  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              status;
		logic              done_res;
		logic [DUR_W-1:0]  length_ms;
		logic [LVL_W-1:0]  rms_level;
		logic [LVL_W-1:0]  peak_level;
		logic [CNT_W-1:0]  sample_total;
		logic [IDX_W-1:0]  store_index;
		logic              taken;
	} res_t;

endpackage

### hw/rtl/recording_level_meter.sv
// Recording level meter: count, peak, RMS and duration of a sample recording.
// Depends on rlm_pkg and recording_level_meter_macros.svh.
// Rate: one word per cycle while idle with no skid word held; a word's result
// is registered at its accept edge. A word ending a non-empty recording passes ST_LOAD,
// the bit-serial mean-square divider (51 steps), the 2-bit-per-step root, then ST_OUT.
// Reset (arst_n low, async) restores the register defaults and clears all counters.
`include "recording_level_meter_macros.svh"

module recording_level_meter (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [3:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// sample stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [23:0]              s_tdata,   // [15:0] sample, [16] stop_request
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [103:0]             m_tdata,   // [0] taken, [20:1] store_index,
	                                            // [41:21] sample_total, [57:42] peak_level,
	                                            // [73:58] rms_level, [103:74] length_ms
	output logic                     m_tlast,   // done_res
	output logic                     m_tuser    // status
);
	import rlm_pkg::*;

	// ---------------------------------------------------------------- config
	logic [CNT_W-1:0]  max_samples_q, min_samples_q, tail_samples_q;
	logic [RATE_W-1:0] sample_rate_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_samples_q  <= RST_MAX_SAMPLES;
			min_samples_q  <= RST_MIN_SAMPLES;
			tail_samples_q <= RST_TAIL_SAMPLES;
			sample_rate_q  <= RST_SAMPLE_RATE;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MAX_SAMPLES:  max_samples_q  <= pwdata[CNT_W-1:0];
				REG_MIN_SAMPLES:  min_samples_q  <= pwdata[CNT_W-1:0];
				REG_TAIL_SAMPLES: tail_samples_q <= pwdata[CNT_W-1:0];
				REG_SAMPLE_RATE:  sample_rate_q  <= pwdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MAX_SAMPLES:  prdata = 32'(max_samples_q);
			REG_MIN_SAMPLES:  prdata = 32'(min_samples_q);
			REG_TAIL_SAMPLES: prdata = 32'(tail_samples_q);
			REG_SAMPLE_RATE:  prdata = 32'(sample_rate_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- recording state
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [LVL_W-1:0]  peak_q;
	logic              tail_act_q;
	logic [CNT_W-1:0]  tail_left_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sq_s1;        // square of the last accepted word, added in the cycle after if it was taken
	logic              sq_vld_s1;

	// per-word decision
	logic                accept;
	logic [SAMPLE_W-1:0] smp;
	logic                stop;
	logic [CNT_W-1:0]    max_eff, min_eff, tail_len, cnt_inc, tail_dec, fin_cnt;
	logic [LVL_W-1:0]    smp_abs, peak_new;
	logic                start_tail, tail_on, end_early, end_late, take, fin, fin_empty;

	assign accept = s_tvalid & s_tready;
	assign smp    = s_tdata[SAMPLE_W-1:0];
	assign stop   = s_tdata[SAMPLE_W];

	always_comb begin
		max_eff    = (max_samples_q > MAX_DEPTH) ? MAX_DEPTH : max_samples_q;
		min_eff    = (min_samples_q < max_eff) ? min_samples_q : max_eff;
		// stop is only looked at on a chunk boundary, once the count reaches the minimum, and only before the tail
		start_tail = !tail_act_q && stop && (cnt_q[CHUNK_BITS-1:0] == '0) && (cnt_q >= min_eff);
		tail_on    = tail_act_q | start_tail;
		tail_len   = start_tail ? tail_samples_q : tail_left_q;
		// limit already reached, or a tail with nothing left: end without the word
		end_early  = (cnt_q >= max_eff) || (tail_on && (tail_len == '0));
		take       = !end_early;
		cnt_inc    = cnt_q + 1'b1;
		tail_dec   = tail_on ? (tail_len - 1'b1) : tail_len;
		end_late   = (cnt_inc >= max_eff) || (tail_on && (tail_dec == '0));
		fin        = end_early | end_late;
		fin_cnt    = take ? cnt_inc : cnt_q;
		fin_empty  = (fin_cnt == '0);
		smp_abs    = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;   // -32768 maps to 32768
		peak_new   = (smp_abs > peak_q) ? smp_abs : peak_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			peak_q      <= '0;
			tail_act_q  <= 1'b0;
			tail_left_q <= '0;
		end else if (accept) begin
			if (fin) begin
				cnt_q       <= '0;
				peak_q      <= '0;
				tail_act_q  <= 1'b0;
				tail_left_q <= '0;
			end else begin
				cnt_q       <= cnt_inc;
				peak_q      <= peak_new;
				tail_act_q  <= tail_on;
				tail_left_q <= tail_dec;
			end
		end
	end

	// sum of squares: multiply at accept, accumulate on the following edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s1 <= 1'b0;
			sum_q     <= '0;
		end else begin
			sq_vld_s1 <= accept & take;
			if (state_q == ST_LOAD)
				sum_q <= '0;
			else if (sq_vld_s1)
				sum_q <= sum_q + SUM_W'(sq_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			sq_s1 <= SQ_W'(smp_abs) * SQ_W'(smp_abs);
	end

	// snapshot of the ending word for the final result
	logic [CNT_W-1:0] fin_cnt_q;
	logic [LVL_W-1:0] fin_peak_q;
	logic [IDX_W-1:0] fin_idx_q;
	logic             fin_taken_q;

	always_ff @(posedge clk) begin
		if (accept && fin) begin
			fin_cnt_q   <= fin_cnt;
			fin_peak_q  <= take ? peak_new : peak_q;
			// a word that is not taken has no buffer position
			fin_idx_q   <= take ? cnt_q[IDX_W-1:0] : '0;
			fin_taken_q <= take;
		end
	end

	// ---------------------------------------------------------------- serial arithmetic
	// mean square: restoring divide, one quotient bit per cycle, quotient
	// shifts in behind the dividend. Duration divide runs beside it while
	// step_q is below DUR_STEPS.
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  mnum_q;
	logic [CNT_W-1:0]  mrem_q;
	logic [DUR_W-1:0]  dnum_q;
	logic [RATE_W-1:0] drem_q;
	logic [SQIN_W-1:0] sqin_q;
	logic [SREM_W-1:0] srem_q;
	logic [LVL_W-1:0]  root_q;

	logic [SUM_W-1:0]  sum_total;
	logic [DUR_W-1:0]  dur_prod;
	logic [RATE_W-1:0] rate_eff;
	logic [CNT_W:0]    m_trial, m_diff;
	logic              m_ge;
	logic [SUM_W-1:0]  mnum_next;
	logic [RATE_W:0]   d_trial, d_diff;
	logic              d_ge;
	logic [SREM_W+1:0] s_trial, s_sub, s_diff;
	logic              s_ge;
	logic              div_last, sqrt_last, dur_run;

	always_comb begin
		sum_total = sq_vld_s1 ? (sum_q + SUM_W'(sq_s1)) : sum_q;
		dur_prod  = DUR_W'(fin_cnt_q) * MS_PER_S;
		rate_eff  = (sample_rate_q == '0) ? RATE_W'(1) : sample_rate_q;

		m_trial   = {mrem_q, mnum_q[SUM_W-1]};
		m_ge      = m_trial >= {1'b0, fin_cnt_q};
		m_diff    = m_trial - {1'b0, fin_cnt_q};
		mnum_next = {mnum_q[SUM_W-2:0], m_ge};

		d_trial   = {drem_q, dnum_q[DUR_W-1]};
		d_ge      = d_trial >= {1'b0, rate_eff};
		d_diff    = d_trial - {1'b0, rate_eff};

		s_trial   = {srem_q, sqin_q[SQIN_W-1 -: 2]};
		s_sub     = {2'b00, root_q, 2'b01};
		s_ge      = s_trial >= s_sub;
		s_diff    = s_trial - s_sub;

		div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
		sqrt_last = (step_q == STEP_W'(SQRT_STEPS - 1));
		dur_run   = (step_q < STEP_W'(DUR_STEPS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_LOAD || (state_q == ST_DIV && div_last)) begin
			step_q <= '0;
		end else if (state_q == ST_DIV || state_q == ST_SQRT) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				mnum_q <= sum_total;
				mrem_q <= '0;
				dnum_q <= dur_prod;
				drem_q <= '0;
			end
			ST_DIV: begin
				mnum_q <= mnum_next;
				mrem_q <= m_ge ? m_diff[CNT_W-1:0] : m_trial[CNT_W-1:0];
				if (dur_run) begin
					dnum_q <= {dnum_q[DUR_W-2:0], d_ge};
					drem_q <= d_ge ? d_diff[RATE_W-1:0] : d_trial[RATE_W-1:0];
				end
				if (div_last) begin
					// mean square is below 2^31; feed it to the root
					sqin_q <= {1'b0, mnum_next[MEAN_W-1:0]};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				sqin_q <= {sqin_q[SQIN_W-3:0], 2'b00};
				srem_q <= s_ge ? s_diff[SREM_W-1:0] : s_trial[SREM_W-1:0];
				root_q <= {root_q[LVL_W-2:0], s_ge};
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- control
	logic out_v_q, skid_v_q;
	logic push, pop;
	res_t push_res, out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && fin && !fin_empty) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (div_last) state_d = ST_SQRT;
			ST_SQRT: if (sqrt_last) state_d = ST_OUT;
			ST_OUT:  if (!skid_v_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE) && !skid_v_q;

	// result source: immediate word result, or the finished statistics
	always_comb begin
		push_res = '0;
		if (state_q == ST_OUT) begin
			push     = !skid_v_q;
			push_res.taken        = fin_taken_q;
			push_res.store_index  = fin_idx_q;
			push_res.done_res     = 1'b1;
			push_res.status       = STATUS_OK;
			push_res.sample_total = fin_cnt_q;
			push_res.peak_level   = fin_peak_q;
			push_res.rms_level    = root_q;
			push_res.length_ms    = dnum_q;
		end else begin
			push = accept && (!fin || fin_empty);
			if (fin) begin
				push_res.done_res = 1'b1;
				push_res.status   = STATUS_EMPTY;
			end else begin
				push_res.taken       = 1'b1;
				push_res.store_index = cnt_q[IDX_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------- output register + skid
	assign pop = out_v_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (out_v_q)
				skid_v_q <= 1'b1;
			else
				out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_v_q ? skid_q : push_res;
		end else if (push) begin
			if (out_v_q)
				skid_q <= push_res;
			else
				out_q <= push_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.length_ms, out_q.rms_level, out_q.peak_level,
	                   out_q.sample_total, out_q.store_index, out_q.taken};
	assign m_tlast  = out_q.done_res;
	assign m_tuser  = out_q.status;

	// ---------------------------------------------------------------- checks
	`RLM_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q, "skid word held with output empty")
	`RLM_ASSERT_NOW(a_busy_no_accept, state_q != ST_IDLE, !s_tready, "word accepted while busy")
	`RLM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= MAX_DEPTH, "sample count beyond buffer depth")
	`RLM_ASSERT_NOW(a_tail_idle_zero, !tail_act_q, tail_left_q == '0, "tail count set without tail")
	`RLM_ASSERT_NEXT(a_fin_starts_math, accept && fin && !fin_empty, state_q == ST_LOAD,
		"non-empty recording end did not start the statistics")

endmodule
